>>> hw/rtl/ohr_pkg.sv
// Package for the overwriting history ring: sizes, operation codes and the
// structs passed between the pointer unit, the byte RAM and the top level.
// No dependencies.
package ohr_pkg;

   // ring storage; the ring holds at most DEPTH-1 bytes
   localparam int DEPTH = 64;
   localparam int PTR_W = $clog2(DEPTH);
   // width that holds a pointer plus a read offset without overflow
   localparam int SUM_W = ((PTR_W > 6) ? PTR_W : 6) + 1;

   localparam logic [15:0] COL_MAX = 16'hFFFF;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [SUM_W-1:0] sum_type;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_FLUSH = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // RAM access issued by the pointer unit
   typedef struct packed {
      logic    wr_en;
      ptr_type wr_addr;
      logic [7:0] wr_data;
      logic    rd_en;
      ptr_type rd_addr;
   } mem_req_type;

   // status as held after the last item
   typedef struct packed {
      logic [5:0]  fill_level;
      logic        overwritten;
      logic [15:0] column_count;
   } status_type;

endpackage

>>> hw/rtl/ohr_if.sv
// Valid/ready channel interfaces for the overwriting history ring:
// the request channel and the result channel. Depends on nothing.
interface ohr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;
   logic [5:0] read_offset;

   modport source (output valid, output operation, output data_byte,
                   output read_offset, input ready);
   modport sink   (input valid, input operation, input data_byte,
                   input read_offset, output ready);
endinterface

interface ohr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_byte;
   logic        read_valid;
   logic [5:0]  fill_level;
   logic        overwritten;
   logic [15:0] column_count;

   modport source (output valid, output read_byte, output read_valid,
                   output fill_level, output overwritten, output column_count,
                   input ready);
   modport sink   (input valid, input read_byte, input read_valid,
                   input fill_level, input overwritten, input column_count,
                   output ready);
endinterface

>>> hw/rtl/overwriting_history_ring.sv
// Overwriting history ring, top level: request handshake, byte RAM, pointer
// unit and the result register. Depends on ohr_pkg, ohr_if, ohr_ram, ohr_ptrs.
//
// Keeps the last 63 bytes pushed, oldest first; a push into a full ring drops
// the oldest byte and sets the overwrite flag until the next flush. Every
// request word gives exactly one result word. From acceptance, a word passes
// through the pointer update and the registered RAM read, then the load of
// the result register. The next word is accepted once the result has been
// taken, so only one word is in the block at a time. The byte RAM needs no
// clearing after reset.
module overwriting_history_ring (
   input  logic     clock,
   input  logic     reset,
   ohr_req_if.sink   req_port,
   ohr_rsp_if.source rsp_port
);
   import ohr_pkg::*;

   mem_req_type mem_req;
   status_type  status;
   logic [7:0]  rd_data;
   logic        read_hit;
   logic        accept;

   logic        pend_ff, pend_in;
   logic        hit_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rbyte_ff;
   logic        rvalid_ff;
   status_type  status_ff;

   assign req_port.ready = ~pend_ff & ~rsp_valid_ff;
   assign accept         = req_port.valid & req_port.ready;

   ohr_ptrs u_ptrs (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (op_type'(req_port.operation)),
      .data_byte   (req_port.data_byte),
      .read_offset (req_port.read_offset),
      .mem_req     (mem_req),
      .read_hit    (read_hit),
      .status      (status)
   );

   ohr_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // control: one word in flight, then the result register
   always_comb begin
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         pend_in = 1'b1;
      end else if (pend_ff) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: read hit at acceptance, result word loaded in the cycle after
   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff <= read_hit;
      end
      if (pend_ff) begin
         rbyte_ff  <= hit_ff ? rd_data : 8'd0;
         rvalid_ff <= hit_ff;
         status_ff <= status;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.read_byte    = rbyte_ff;
   assign rsp_port.read_valid   = rvalid_ff;
   assign rsp_port.fill_level   = status_ff.fill_level;
   assign rsp_port.overwritten  = status_ff.overwritten;
   assign rsp_port.column_count = status_ff.column_count;

endmodule

>>> hw/rtl/ohr_ram.sv
// Byte store of the history ring: one write port, one read port with
// registered read data. Depends on ohr_pkg.
module ohr_ram (
   input  logic                clock,
   input  ohr_pkg::mem_req_type mem_req,
   output logic [7:0]          rd_data
);
   import ohr_pkg::*;

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/ohr_ptrs.sv
// Pointer unit of the history ring: oldest and write pointers, aligned flag
// and column count; turns each accepted push into a RAM write and each read hit into a RAM read.
// Depends on ohr_pkg.
module ohr_ptrs (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  ohr_pkg::op_type      operation,
   input  logic [7:0]           data_byte,
   input  logic [5:0]           read_offset,
   output ohr_pkg::mem_req_type mem_req,
   output logic                 read_hit,
   output ohr_pkg::status_type  status
);
   import ohr_pkg::*;

   ptr_type     oldest_ff, oldest_in;
   ptr_type     wptr_ff, wptr_in;
   logic        aligned_ff, aligned_in;
   logic [15:0] count_ff, count_in;

   sum_type fill;
   sum_type idx_sum;
   sum_type idx_wrap;
   logic    full;

   function automatic ptr_type wrap_inc(ptr_type p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // fill level, modulo the ring depth
   always_comb begin
      if (wptr_ff >= oldest_ff) begin
         fill = SUM_W'(wptr_ff) - SUM_W'(oldest_ff);
      end else begin
         fill = SUM_W'(wptr_ff) + SUM_W'(DEPTH) - SUM_W'(oldest_ff);
      end
   end

   assign full = (fill >= SUM_W'(DEPTH - 1));

   // read address; only used on a hit, where offset < fill < DEPTH
   assign idx_sum  = SUM_W'(oldest_ff) + SUM_W'(read_offset);
   assign idx_wrap = (idx_sum >= SUM_W'(DEPTH)) ? idx_sum - SUM_W'(DEPTH) : idx_sum;
   assign read_hit = (operation == OP_READ) && (SUM_W'(read_offset) < fill);

   // state update per accepted word
   always_comb begin
      oldest_in  = oldest_ff;
      wptr_in    = wptr_ff;
      aligned_in = aligned_ff;
      count_in   = count_ff;
      if (accept) begin
         case (operation)
            OP_PUSH: begin
               if (full) begin
                  oldest_in  = wrap_inc(oldest_ff);
                  aligned_in = 1'b0;
               end
               wptr_in = wrap_inc(wptr_ff);
               if (count_ff != COL_MAX) begin
                  count_in = count_ff + 16'd1;
               end
            end
            OP_FLUSH: begin
               oldest_in  = '0;
               wptr_in    = '0;
               aligned_in = 1'b1;
               count_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff  <= '0;
         wptr_ff    <= '0;
         aligned_ff <= 1'b1;
         count_ff   <= '0;
      end else begin
         oldest_ff  <= oldest_in;
         wptr_ff    <= wptr_in;
         aligned_ff <= aligned_in;
         count_ff   <= count_in;
      end
   end

   // RAM access
   assign mem_req.wr_en   = accept && (operation == OP_PUSH);
   assign mem_req.wr_addr = wptr_ff;
   assign mem_req.wr_data = data_byte;
   assign mem_req.rd_en   = accept && read_hit;
   assign mem_req.rd_addr = idx_wrap[PTR_W-1:0];

   // status of the registered state
   assign status.fill_level   = fill[5:0];
   assign status.overwritten  = ~aligned_ff;
   assign status.column_count = count_ff;

endmodule
